>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed outside reset");

// Property checked at every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> sv/hktc_pkg.sv
// ----------------------------------------------------------------------------
// hktc_pkg
// Types and constants of the hashed key table cache.
// ----------------------------------------------------------------------------
`default_nettype none

package hktc_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned KEY_W = 32;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_STATS  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    RES_LOOKUP = 2'd0,
    RES_INSERT = 2'd1,
    RES_STATS  = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic      fold;
    logic      scan_start;
    logic      scan_run;
    logic      insert;
    logic      clear;
    logic      load_out;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/hktc_ctrl.sv
// ----------------------------------------------------------------------------
// hktc_ctrl
// Sequencer: accepts beats, starts the bank search and loads results.
// ----------------------------------------------------------------------------
`default_nettype none

module hktc_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [1:0]        in_op,
  input  wire               in_last,
  input  hktc_pkg::sts_t    sts,
  output hktc_pkg::cmd_t    cmd
);
  import hktc_pkg::*;

  state_t state;
  state_t state_next;
  logic   acc;
  op_t    op;

  assign op = op_t'(in_op);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && op == OP_BYTE && in_last) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.scan_done && sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = !rst && (state == ST_IDLE) && sts.out_free;
    acc            = in_valid && in_ready;
    cmd.fold       = acc && op == OP_BYTE;
    cmd.scan_start = acc && op == OP_BYTE && in_last;
    cmd.scan_run   = (state == ST_LOOKUP);
    cmd.insert     = acc && op == OP_INSERT;
    cmd.clear      = acc && op == OP_CLEAR;
    cmd.load_out   = (acc && op != OP_BYTE)
                  || ((state == ST_LOOKUP) && sts.scan_done && sts.out_free);
    if (state == ST_LOOKUP) begin
      cmd.kind = RES_LOOKUP;
    end else if (op == OP_INSERT) begin
      cmd.kind = RES_INSERT;
    end else begin
      cmd.kind = RES_STATS;
    end
  end

endmodule

`default_nettype wire

>>> sv/hktc_dpath.sv
// ----------------------------------------------------------------------------
// hktc_dpath
// Hash register, fill counts, entry memory, search walker and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hktc_dpath #(
  parameter int unsigned ENTRIES = 128
) (
  input  wire                  clk,
  input  wire                  rst,
  input  hktc_pkg::cmd_t       cmd,
  output hktc_pkg::sts_t       sts,
  input  wire                  in_bank,
  input  wire  [7:0]           in_byte,
  input  wire  [31:0]          in_handle,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_hit,
  output logic                 out_full,
  output logic [31:0]          out_handle,
  output logic [7:0]           out_count_pix,
  output logic [7:0]           out_count_lin
);
  import hktc_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned DEPTH = 2 ** (IW + 1);

  logic [KEY_W+HANDLE_W-1:0] mem [DEPTH];

  logic [31:0]         hash;
  logic [31:0]         hash_next;
  logic [KEY_W-1:0]    key;
  logic                bank_q;
  logic [CW-1:0]       cnt_lin;
  logic [CW-1:0]       cnt_pix;
  logic [CW-1:0]       cnt_ins;
  logic [CW-1:0]       cnt_scan;
  logic                full;
  logic [CW-1:0]       scan_idx;
  logic                rd_pend;
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;
  logic                scan_hit;
  logic                scan_done;
  logic [HANDLE_W-1:0] hit_handle;
  logic                more;
  logic                match;
  logic                issue;
  logic [CW+7:0]       ext_lin;
  logic [CW+7:0]       ext_pix;
  logic [7:0]          sat_lin;
  logic [7:0]          sat_pix;

  assign hash_next = (hash ^ {24'd0, in_byte}) * FNV_PRIME;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash   <= FNV_BASIS;
      key    <= '0;
      bank_q <= 1'b0;
    end else if (cmd.scan_start) begin
      hash   <= FNV_BASIS;
      key    <= (hash_next == 32'd0) ? 32'd1 : hash_next;
      bank_q <= in_bank;
    end else if (cmd.fold) begin
      hash <= hash_next;
    end
  end

  assign cnt_ins = in_bank ? cnt_pix : cnt_lin;
  assign full    = (cnt_ins == CW'(ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_lin <= '0;
      cnt_pix <= '0;
    end else if (cmd.clear) begin
      cnt_lin <= '0;
      cnt_pix <= '0;
    end else if (cmd.insert && !full) begin
      if (in_bank) begin
        cnt_pix <= cnt_pix + CW'(1);
      end else begin
        cnt_lin <= cnt_lin + CW'(1);
      end
    end
  end

  // Entries are filled in order and only cleared all at once, so the valid
  // entries of a bank are always those below its fill count.
  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      mem[{in_bank, cnt_ins[IW-1:0]}] <= {key, in_handle};
    end
  end

  assign cnt_scan = bank_q ? cnt_pix : cnt_lin;
  assign more     = scan_idx < cnt_scan;
  assign match    = rd_pend && (rd_key == key);
  assign issue    = cmd.scan_run && !scan_done && more && !match;

  always_ff @(posedge clk) begin
    if (issue) begin
      {rd_key, rd_handle} <= mem[{bank_q, scan_idx[IW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      rd_pend   <= 1'b0;
      scan_hit  <= 1'b0;
      scan_done <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx  <= '0;
      rd_pend   <= 1'b0;
      scan_hit  <= 1'b0;
      scan_done <= 1'b0;
    end else if (cmd.scan_run && !scan_done) begin
      rd_pend <= issue;
      if (issue) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (match) begin
        scan_hit  <= 1'b1;
        scan_done <= 1'b1;
      end else if (!more) begin
        scan_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run && !scan_done && match) begin
      hit_handle <= rd_handle;
    end
  end

  assign ext_lin = (CW + 8)'(cnt_lin);
  assign ext_pix = (CW + 8)'(cnt_pix);
  assign sat_lin = (ext_lin > (CW + 8)'(255)) ? 8'hFF : ext_lin[7:0];
  assign sat_pix = (ext_pix > (CW + 8)'(255)) ? 8'hFF : ext_pix[7:0];

  assign sts.scan_done = scan_done;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      unique case (cmd.kind)
        RES_LOOKUP: begin
          out_hit       <= scan_hit;
          out_full      <= 1'b0;
          out_handle    <= scan_hit ? hit_handle : '0;
          out_count_pix <= '0;
          out_count_lin <= '0;
        end
        RES_INSERT: begin
          out_hit       <= 1'b0;
          out_full      <= full;
          out_handle    <= '0;
          out_count_pix <= '0;
          out_count_lin <= '0;
        end
        default: begin
          out_hit       <= 1'b0;
          out_full      <= 1'b0;
          out_handle    <= '0;
          out_count_pix <= sat_pix;
          out_count_lin <= sat_lin;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/hashed_key_table_cache.sv
// ----------------------------------------------------------------------------
// hashed_key_table_cache
// Two-bank handle table keyed by an FNV-1a hash of a streamed path.
// ----------------------------------------------------------------------------
// Input beats carry the operation and bank in s_tuser and a path byte or a
// handle in s_tdata. Path bytes fold into the running hash at one beat per
// cycle while s_tready is high; the beat with s_tlast high latches the key and
// searches the bank. The search reads one entry per cycle from the entry memory
// until it finds the key or passes the fill count of the bank. Insert, stats and
// clear beats give their result in the cycle after acceptance. Every lookup,
// insert, stats or clear beat gives exactly one result beat on the master side;
// a non-final path byte gives none. Reset empties both banks and restores the
// hash basis. While a result waits in the output register and m_tready is low,
// the slave side takes no beat; a waiting lookup result also holds the block in
// its search.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_key_table_cache #(
  parameter int unsigned ENTRIES = 128
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // path_byte[7:0], handle_in[39:8]
  input  wire  [2:0]  s_tuser,   // operation[1:0], bank[2]
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,   // handle_out[31:0], count_pixel_art[39:32],
                                 // count_linear[47:40]
  output logic [1:0]  m_tuser    // hit[0], full_res[1]
);
  import hktc_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        hit;
  logic        full_res;
  logic [31:0] handle_out;
  logic [7:0]  count_pixel_art;
  logic [7:0]  count_linear;

  hktc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser[1:0]),
    .in_last  (s_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  hktc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_bank       (s_tuser[2]),
    .in_byte       (s_tdata[7:0]),
    .in_handle     (s_tdata[39:8]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_hit       (hit),
    .out_full      (full_res),
    .out_handle    (handle_out),
    .out_count_pix (count_pixel_art),
    .out_count_lin (count_linear)
  );

  assign m_tdata = {count_linear, count_pixel_art, handle_out};
  assign m_tuser = {full_res, hit};

endmodule

`default_nettype wire

>>> sv/hktc_checker.sv
// ----------------------------------------------------------------------------
// hktc_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hktc_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [47:0] m_tdata,
  input wire [1:0]  m_tuser
);

  `ASSERT_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `ASSERT_RST(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !m_tvalid)
  `ASSERT_RST(a_hit_not_full, clk, rst, m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
  `ASSERT_RST(a_hit_no_counts, clk, rst, m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata[47:32] == 16'd0)

endmodule

bind hashed_key_table_cache hktc_checker u_hktc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

>>> sim/hashed_key_table_cache_tb.sv
// ----------------------------------------------------------------------------
// hashed_key_table_cache_tb
// Self-checking testbench for the two-bank hashed key table.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own FNV-1a hash, latched key and both banks of
// entries. It works out the expected result of every accepted input beat and
// checks each result beat against the oldest expectation. A short directed
// list covers the field extremes, every operation, a zero path byte and a
// path whose hash is zero. After that come random lookup and insert sequences
// with noise, filling a bank past capacity in each phase. Both sides idle at
// random in the first two phases, and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------

module hashed_key_table_cache_tb;
  import hktc_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 128;
  localparam int unsigned POOL_SIZE = 16;
  localparam int unsigned PHASE_BEATS = 443;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic        hit;
    logic        full;
    logic [31:0] handle;
    logic [7:0]  count_pixel_art;
    logic [7:0]  count_linear;
  } table_result_t;

  class key_table_predictor;
    logic [31:0] running_hash;
    logic [31:0] latched_key;
    logic [31:0] stored_key [2][TABLE_ENTRIES];
    logic [31:0] stored_handle [2][TABLE_ENTRIES];
    bit          occupied [2][TABLE_ENTRIES];
    table_result_t pending_results [$];
    int unsigned failures, reported;
    int unsigned lookups, hits, inserts, fulls, queries;

    function new();
      running_hash = FNV_BASIS;
      latched_key = '0;
      foreach (occupied[b, i]) occupied[b][i] = 1'b0;
    endfunction

    static function logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
      return (h ^ {24'd0, b}) * FNV_PRIME;
    endfunction

    function logic [7:0] occupied_count(int b);
      int n;
      n = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) n += occupied[b][i];
      return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function void absorb_beat(op_t op, bit bank, logic [7:0] pbyte, bit last,
                              logic [31:0] handle);
      table_result_t r;
      int slot;
      r = '0;
      case (op)
        OP_BYTE: begin
          running_hash = fold_byte(running_hash, pbyte);
          if (!last) return;
          latched_key = (running_hash == 0) ? 32'd1 : running_hash;
          running_hash = FNV_BASIS;
          lookups++;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (occupied[bank][i] && stored_key[bank][i] == latched_key) begin
              r.hit = 1'b1;
              r.handle = stored_handle[bank][i];
              break;
            end
          end
          hits += r.hit;
        end
        OP_INSERT: begin
          slot = -1;
          inserts++;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!occupied[bank][i]) begin
              slot = i;
              break;
            end
          end
          if (slot < 0) begin
            r.full = 1'b1;
            fulls++;
          end else begin
            stored_key[bank][slot] = latched_key;
            stored_handle[bank][slot] = handle;
            occupied[bank][slot] = 1'b1;
          end
        end
        default: begin
          queries++;
          r.count_pixel_art = occupied_count(1);
          r.count_linear = occupied_count(0);
          if (op == OP_CLEAR) foreach (occupied[b, i]) occupied[b][i] = 1'b0;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void compare_result(logic [47:0] data, logic [1:0] user);
      table_result_t got, want;
      got.hit = user[0];
      got.full = user[1];
      got.handle = data[31:0];
      got.count_pixel_art = data[39:32];
      got.count_linear = data[47:40];
      if (pending_results.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("Unexpected result beat: hit=%0d full=%0d handle=%h pa=%0d lin=%0d",
                   got.hit, got.full, got.handle, got.count_pixel_art, got.count_linear);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.hit !== want.hit || got.full !== want.full || got.handle !== want.handle ||
          got.count_pixel_art !== want.count_pixel_art ||
          got.count_linear !== want.count_linear) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("Mismatch: expected hit=%0d full=%0d handle=%h pa=%0d lin=%0d",
                   want.hit, want.full, want.handle, want.count_pixel_art,
                   want.count_linear);
          $display("          actual   hit=%0d full=%0d handle=%h pa=%0d lin=%0d",
                   got.hit, got.full, got.handle, got.count_pixel_art, got.count_linear);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // path_byte[7:0], handle_in[39:8]
  logic [2:0]  s_tuser = '0;   // operation[1:0], bank[2]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // handle_out[31:0], count_pixel_art[39:32],
                               // count_linear[47:40]
  logic [1:0]  m_tuser;        // hit[0], full_res[1]

  key_table_predictor predictor = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  bit          hold_request = 1'b0;
  logic [39:0] zero_path;
  logic [7:0]  pool_bytes [POOL_SIZE][8];
  int unsigned pool_len [POOL_SIZE];

  hashed_key_table_cache #(
    .ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
               predictor.pending_results.size());
      $display("hashed_key_table_cache verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      predictor.absorb_beat(op_t'(s_tuser[1:0]), s_tuser[2], s_tdata[7:0], s_tlast,
                            s_tdata[39:8]);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) predictor.compare_result(m_tdata, m_tuser);
  end

  initial begin
    int unsigned hold_left;
    bit hold_served;
    hold_left = 0;
    hold_served = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold_left = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Builds five nonzero bytes whose FNV-1a hash is zero. The last two bytes
  // are solved backwards through the inverse of the prime, so only the first
  // three are searched.
  function automatic logic [39:0] find_zero_hash_path();
    logic [31:0] inv, h1, h2, h3, t;
    logic [7:0] b4;
    int unsigned v;
    int unsigned tail [logic [23:0]];
    inv = FNV_PRIME;
    repeat (5) inv = inv * (32'd2 - FNV_PRIME * inv);
    for (int k = 1; k < 256; k++) begin
      t = k * inv;
      tail[t[31:8]] = k;
    end
    for (int b1 = 1; b1 < 256; b1++) begin
      h1 = key_table_predictor::fold_byte(FNV_BASIS, b1[7:0]);
      for (int b2 = 1; b2 < 256; b2++) begin
        h2 = key_table_predictor::fold_byte(h1, b2[7:0]);
        for (int b3 = 1; b3 < 256; b3++) begin
          h3 = key_table_predictor::fold_byte(h2, b3[7:0]);
          if (tail.exists(h3[31:8])) begin
            v = tail[h3[31:8]];
            t = v * inv;
            b4 = h3[7:0] ^ t[7:0];
            if (b4 != 0) return {v[7:0], b4, b3[7:0], b2[7:0], b1[7:0]};
          end
        end
      end
    end
    return '0;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_beat(op_t op, bit bank, logic [7:0] pbyte, bit last,
                           logic [31:0] handle);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {bank, op};
    s_tdata <= {handle, pbyte};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_lookup(int idx, bit bank);
    int len;
    logic [7:0] b;
    if (idx < 0) len = $urandom_range(1, 6);
    else if (idx == POOL_SIZE) len = 5;
    else len = pool_len[idx];
    for (int i = 0; i < len; i++) begin
      if (idx < 0) b = rand_byte();
      else if (idx == POOL_SIZE) b = zero_path[8*i +: 8];
      else b = pool_bytes[idx][i];
      send_beat(OP_BYTE, bank, b, i == len - 1, $urandom());
    end
  endtask

  task automatic send_insert(bit bank);
    send_beat(OP_INSERT, bank, rand_byte(), rand_bit(), $urandom());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (predictor.pending_results.size() != 0);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned target, pick;
    bit bank;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = beats_sent + PHASE_BEATS;
    bank = rand_bit();
    send_lookup(int'($urandom_range(0, POOL_SIZE)), bank);
    repeat (TABLE_ENTRIES + 3) send_insert(bank);
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      bank = rand_bit();
      if (pick < 2) begin
        send_beat(OP_CLEAR, bank, rand_byte(), rand_bit(), $urandom());
      end else if (pick < 7) begin
        send_beat(OP_STATS, bank, rand_byte(), rand_bit(), $urandom());
      end else if (pick < 15) begin
        if ($urandom_range(0, 1)) send_insert(bank);
        else send_beat(OP_BYTE, bank, rand_byte(), 1'b0, $urandom());
      end else begin
        if ($urandom_range(0, 99) < 70) send_lookup(int'($urandom_range(0, POOL_SIZE)), bank);
        else send_lookup(-1, bank);
        if ($urandom_range(0, 99) < 55) send_insert(bank);
        if ($urandom_range(0, 99) < 8) repeat ($urandom_range(2, 30)) send_insert(bank);
      end
    end
    wait_drained();
  endtask

  initial begin
    zero_path = find_zero_hash_path();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_len[i] = $urandom_range(1, 8);
      for (int j = 0; j < 8; j++) pool_bytes[i][j] = rand_byte();
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: insert before any lookup stores key zero, which must
    // never match; the zero-hash path must look up under key one.
    send_idle_pct = 15;
    recv_idle_pct = 78;
    send_beat(OP_INSERT, 1'b0, 8'h01, 1'b1, 32'hFFFF_FFFF);
    send_beat(OP_BYTE, 1'b0, 8'hFF, 1'b1, 32'h0);
    send_beat(OP_INSERT, 1'b1, 8'hFF, 1'b0, 32'h0);
    send_beat(OP_BYTE, 1'b1, 8'h01, 1'b1, 32'hFFFF_FFFF);
    send_beat(OP_BYTE, 1'b1, 8'h00, 1'b0, 32'h0);
    send_beat(OP_BYTE, 1'b1, 8'hFF, 1'b1, 32'h0);
    send_lookup(POOL_SIZE, 1'b0);
    send_beat(OP_INSERT, 1'b0, 8'h80, 1'b1, 32'hA5A5_5A5A);
    send_lookup(POOL_SIZE, 1'b0);
    send_beat(OP_STATS, 1'b0, 8'hFF, 1'b0, 32'hFFFF_FFFF);
    send_beat(OP_BYTE, 1'b1, 8'hFF, 1'b1, 32'h5A5A_A5A5);
    send_beat(OP_CLEAR, 1'b1, 8'h01, 1'b1, 32'h0);
    send_beat(OP_STATS, 1'b1, 8'h7F, 1'b1, 32'h0);
    wait_drained();

    run_phase(15, 78);
    run_phase(78, 15);
    hold_request = 1'b1;
    run_phase(0, 0);

    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    $display("Covered %0d beats: %0d lookups (%0d hits), %0d inserts (%0d full), %0d stats/clear.",
             beats_sent, predictor.lookups, predictor.hits, predictor.inserts,
             predictor.fulls, predictor.queries);
    $display("Each phase filled a bank past capacity; one %0d-cycle output stall; %0d failures.",
             HOLD_CYCLES, predictor.failures);
    if (predictor.failures == 0) begin
      $display("hashed_key_table_cache verification clean");
    end else begin
      $display("hashed_key_table_cache verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/hktc_pkg.sv
sv/hktc_ctrl.sv
sv/hktc_dpath.sv
sv/hashed_key_table_cache.sv
sv/hktc_checker.sv
sim/hashed_key_table_cache_tb.sv
